// ===== hdl/pbpm_pkg.sv =====
// Shared codes and control types for the page buffer pool manager.
// Used by the frame cell and the top level; no other dependencies.
package pbpm_pkg;

	// Operation codes
	localparam logic [2:0] OP_GET    = 3'd0;
	localparam logic [2:0] OP_UNPIN  = 3'd1;
	localparam logic [2:0] OP_DIRTY  = 3'd2;
	localparam logic [2:0] OP_COMMIT = 3'd3;
	localparam logic [2:0] OP_CLOSE  = 3'd4;

	// Result status codes
	localparam logic [2:0] ST_HIT    = 3'd0;
	localparam logic [2:0] ST_FILLED = 3'd1;
	localparam logic [2:0] ST_FULL   = 3'd2;
	localparam logic [2:0] ST_NP     = 3'd3;
	localparam logic [2:0] ST_CLOSED = 3'd4;

	localparam int FILE_W = 8;
	localparam int PAGE_W = 32;
	localparam int IDX_W  = 4;
	localparam int DATA_W = 48;

	// Per-frame update strobes
	typedef struct packed {
		logic fill;
		logic pin;
		logic unpin;
		logic dirty_set;
		logic dirty_clr;
		logic invalidate;
	} frame_ctl_t;

	// Per-frame status toward the control
	typedef struct packed {
		logic hit;
		logic file_hit;
		logic valid;
		logic pinned;
		logic dirty;
	} frame_sts_t;

endpackage

// ===== hdl/pbpm_frame_cell.sv =====
// One frame table entry: tag, page and valid/pinned/dirty marks plus its compare.
// Depends on pbpm_pkg.
module pbpm_frame_cell import pbpm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  frame_ctl_t        ctl,
	input  logic [FILE_W-1:0] key_file,
	input  logic [PAGE_W-1:0] key_page,
	output frame_sts_t        sts,
	output logic [FILE_W-1:0] file,
	output logic [PAGE_W-1:0] page
);

	logic [FILE_W-1:0] file_q;
	logic [PAGE_W-1:0] page_q;
	logic              valid_q, pinned_q, dirty_q;

	// Entry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_q   <= '0;
			page_q   <= '0;
			valid_q  <= 1'b0;
			pinned_q <= 1'b0;
			dirty_q  <= 1'b0;
		end else begin
			if (ctl.fill) begin
				file_q  <= key_file;
				page_q  <= key_page;
				valid_q <= 1'b1;
			end else if (ctl.invalidate) begin
				valid_q <= 1'b0;
			end
			if (ctl.pin)
				pinned_q <= 1'b1;
			else if (ctl.unpin)
				pinned_q <= 1'b0;
			if (ctl.dirty_set)
				dirty_q <= 1'b1;
			else if (ctl.dirty_clr || ctl.fill)
				dirty_q <= 1'b0;
		end
	end

	// Tag compare
	always_comb begin
		sts.file_hit = valid_q && (file_q == key_file);
		sts.hit      = sts.file_hit && (page_q == key_page);
		sts.valid    = valid_q;
		sts.pinned   = pinned_q;
		sts.dirty    = dirty_q;
	end

	assign file = file_q;
	assign page = page_q;

endmodule

// ===== hdl/pbpm_order_cell.sv =====
// One slot of the oldest-first unpinned frame queue; shifts from its upper neighbor.
// No package dependencies.
module pbpm_order_cell #(
	parameter int IW       = 4,
	parameter int RESET_ID = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          live,       // slot holds a queued frame
	input  logic          remove,
	input  logic [IW-1:0] tgt,
	input  logic          chain_in,   // target found in a lower slot
	output logic          chain_out,
	input  logic [IW-1:0] next_id,    // id of the upper neighbor
	input  logic          append,     // this slot is the first free slot past the tail
	input  logic [IW-1:0] app_id,
	output logic [IW-1:0] id
);

	logic [IW-1:0] id_q;

	assign chain_out = chain_in || (live && (id_q == tgt));

	// Close the gap by taking the neighbor's id, or take the appended id
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q <= IW'(RESET_ID);
		end else if (remove && chain_out) begin
			id_q <= next_id;
		end else if (append) begin
			id_q <= app_id;
		end
	end

	assign id = id_q;

endmodule

// ===== hdl/page_buffer_pool_manager.sv =====
// Page buffer pool frame table with oldest-released victim choice. One transaction at a
// time: get/unpin/dirty/commit pass through accept, tag lookup and update; close passes
// through accept, tag lookup, start, a walk over every frame and a final result. Each
// result waits while the single-result output register is full and not taken. The
// unpinned queue is a chain of cells that shifts one slot toward the head on removal.
// Depends on pbpm_pkg, pbpm_frame_cell and pbpm_order_cell.
module page_buffer_pool_manager import pbpm_pkg::*; #(
	parameter int FRAMES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,  // operation[2:0], file_id[10:3], page_number[42:11]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,  // frame_index[3:0], status[6:4], writeback[7],
	                                    // writeback_file[15:8], writeback_page[47:16]
	output logic              m_tlast
);

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW = $clog2(FRAMES + 1);

	typedef enum logic [2:0] {S_IDLE, S_LOOK, S_EXEC, S_CLOSE, S_DONE} state_t;

	state_t            state_q;
	logic [2:0]        op_q;
	logic [FILE_W-1:0] fid_q;
	logic [PAGE_W-1:0] pg_q;
	logic              hit_q;
	logic [IW-1:0]     hit_idx_q;
	logic [IW-1:0]     idx_q;
	logic [CW-1:0]     count_q;

	logic              out_valid_q, out_last_q, out_wb_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [2:0]        out_st_q;
	logic [FILE_W-1:0] out_wf_q;
	logic [PAGE_W-1:0] out_wp_q;

	frame_ctl_t        ctl   [FRAMES];
	frame_sts_t        sts   [FRAMES];
	logic [FILE_W-1:0] files [FRAMES];
	logic [PAGE_W-1:0] pages [FRAMES];
	logic [FRAMES-1:0] pinned_vec;

	logic [IW-1:0]     ord_id [FRAMES];
	logic [FRAMES:0]   chain;
	logic              ord_remove, ord_append;
	logic [IW-1:0]     ord_tgt, ord_app_id;

	// Frame cells
	for (genvar g = 0; g < FRAMES; g++) begin : g_frame
		pbpm_frame_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[g]),
			.key_file (fid_q),
			.key_page (pg_q),
			.sts      (sts[g]),
			.file     (files[g]),
			.page     (pages[g])
		);
		assign pinned_vec[g] = sts[g].pinned;
	end

	// Unpinned queue, head at slot 0
	assign chain[0] = 1'b0;
	for (genvar g = 0; g < FRAMES; g++) begin : g_order
		logic [IW-1:0] nxt;
		if (g == FRAMES - 1) begin : g_top
			assign nxt = ord_id[g];
		end else begin : g_mid
			assign nxt = ord_id[g+1];
		end
		pbpm_order_cell #(.IW(IW), .RESET_ID(FRAMES - 1 - g)) u_ord (
			.clk       (clk),
			.arst_n    (arst_n),
			.live      (CW'(g) < count_q),
			.remove    (ord_remove),
			.tgt       (ord_tgt),
			.chain_in  (chain[g]),
			.chain_out (chain[g+1]),
			.next_id   (nxt),
			.append    (ord_append && (CW'(g) == count_q)),
			.app_id    (ord_app_id),
			.id        (ord_id[g])
		);
	end

	// Lowest matching frame
	logic          look_hit;
	logic [IW-1:0] look_idx;
	always_comb begin
		look_hit = 1'b0;
		look_idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (sts[i].hit) begin
				look_hit = 1'b1;
				look_idx = IW'(i);
			end
		end
	end

	logic slot_free;
	assign slot_free = !out_valid_q || m_tready;

	// Frame index narrowed/widened to the port width
	function automatic logic [IDX_W-1:0] to_idx(input logic [IW-1:0] f);
		logic [IW+IDX_W-1:0] t;
		t = {{IDX_W{1'b0}}, f};
		return t[IDX_W-1:0];
	endfunction

	// Per-item control
	logic              res_en, res_last, res_wb, step;
	logic [IDX_W-1:0]  res_idx;
	logic [2:0]        res_st;
	logic [FILE_W-1:0] res_wf;
	logic [PAGE_W-1:0] res_wp;
	logic [IW-1:0]     victim;
	logic              fill_now;

	assign victim = ord_id[0];

	always_comb begin
		for (int i = 0; i < FRAMES; i++)
			ctl[i] = '0;
		ord_remove = 1'b0;
		ord_append = 1'b0;
		ord_tgt    = '0;
		ord_app_id = '0;
		res_en     = 1'b0;
		res_last   = 1'b1;
		res_wb     = 1'b0;
		res_idx    = '0;
		res_st     = ST_NP;
		res_wf     = '0;
		res_wp     = '0;
		step       = 1'b0;
		fill_now   = 1'b0;
		case (state_q)
			S_EXEC: begin
				if (op_q == OP_CLOSE) begin
					step = 1'b1;
				end else if (slot_free) begin
					step   = 1'b1;
					res_en = 1'b1;
					if (op_q == OP_GET && !hit_q) begin
						if (count_q == '0) begin
							res_st = ST_FULL;
						end else begin
							fill_now           = 1'b1;
							res_st             = ST_FILLED;
							res_idx            = to_idx(victim);
							res_wb             = sts[victim].valid && sts[victim].dirty;
							res_wf             = res_wb ? files[victim] : '0;
							res_wp             = res_wb ? pages[victim] : '0;
							ord_remove         = 1'b1;
							ord_tgt            = victim;
							ctl[victim].fill   = 1'b1;
							ctl[victim].pin    = 1'b1;
						end
					end else if (hit_q && op_q <= OP_COMMIT) begin
						res_st  = ST_HIT;
						res_idx = to_idx(hit_idx_q);
						case (op_q)
							OP_GET: begin
								if (!sts[hit_idx_q].pinned) begin
									ctl[hit_idx_q].pin = 1'b1;
									ord_remove         = 1'b1;
									ord_tgt            = hit_idx_q;
								end
							end
							OP_DIRTY: ctl[hit_idx_q].dirty_set = 1'b1;
							OP_UNPIN, OP_COMMIT: begin
								if (op_q == OP_COMMIT) begin
									res_wb                     = sts[hit_idx_q].dirty;
									res_wf                     = res_wb ? files[hit_idx_q] : '0;
									res_wp                     = res_wb ? pages[hit_idx_q] : '0;
									ctl[hit_idx_q].dirty_clr   = 1'b1;
								end
								if (sts[hit_idx_q].pinned) begin
									ctl[hit_idx_q].unpin = 1'b1;
									ord_append           = 1'b1;
									ord_app_id           = hit_idx_q;
								end
							end
							default: ;
						endcase
					end
				end
			end
			S_CLOSE: begin
				if (sts[idx_q].file_hit && sts[idx_q].dirty) begin
					if (slot_free) begin
						step     = 1'b1;
						res_en   = 1'b1;
						res_last = 1'b0;
						res_st   = ST_CLOSED;
						res_idx  = to_idx(idx_q);
						res_wb   = 1'b1;
						res_wf   = fid_q;
						res_wp   = pages[idx_q];
					end
				end else begin
					step = 1'b1;
				end
				if (step && sts[idx_q].file_hit) begin
					ctl[idx_q].invalidate = 1'b1;
					ctl[idx_q].dirty_clr  = 1'b1;
					if (sts[idx_q].pinned) begin
						ctl[idx_q].unpin = 1'b1;
						ord_append       = 1'b1;
						ord_app_id       = idx_q;
					end
				end
			end
			S_DONE: begin
				if (slot_free) begin
					step   = 1'b1;
					res_en = 1'b1;
					res_st = ST_CLOSED;
				end
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);

	// Sequencer and item registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= CW'(FRAMES);
			idx_q     <= '0;
			hit_q     <= 1'b0;
			hit_idx_q <= '0;
			op_q      <= '0;
			fid_q     <= '0;
			pg_q      <= '0;
		end else begin
			if (ord_remove)
				count_q <= count_q - CW'(1);
			else if (ord_append)
				count_q <= count_q + CW'(1);
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tdata[2:0];
						fid_q   <= s_tdata[10:3];
						pg_q    <= s_tdata[42:11];
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					hit_q     <= look_hit;
					hit_idx_q <= look_idx;
					idx_q     <= '0;
					state_q   <= S_EXEC;
				end
				S_EXEC: begin
					if (step)
						state_q <= (op_q == OP_CLOSE) ? S_CLOSE : S_IDLE;
				end
				S_CLOSE: begin
					if (step) begin
						idx_q <= idx_q + IW'(1);
						if (idx_q == IW'(FRAMES - 1))
							state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (step)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_en) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_en) begin
			out_idx_q  <= res_idx;
			out_st_q   <= res_st;
			out_wb_q   <= res_wb;
			out_wf_q   <= res_wf;
			out_wp_q   <= res_wp;
			out_last_q <= res_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_wp_q, out_wf_q, out_wb_q, out_st_q, out_idx_q};
	assign m_tlast  = out_last_q;

	// The pinned frame count plus the queue length always equals the frame count
	a_count_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(32'($countones(pinned_vec)) + 32'(count_q)) == 32'(FRAMES))
		else $error("pinned frames and queue length disagree");

	// A refill never picks a pinned frame
	a_victim_free: assert property (@(posedge clk) disable iff (!arst_n)
		fill_now |-> !sts[victim].pinned)
		else $error("victim frame is pinned");

	// Queue never grows and shrinks in the same cycle
	a_queue_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ord_remove && ord_append))
		else $error("queue remove and append together");

endmodule
